// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/qphs_pkg.sv -----
package qphs_pkg;

  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int SIZE_W     = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd11;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 5'd2;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERT_FREE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERT_OVERWRITE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED          = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DELETE_MISS      = 2'd3;

endpackage

// ----- rtl/qphs_if.sv -----
interface qphs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [qphs_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface qphs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [qphs_pkg::STATUS_W-1:0]     status;
  logic [qphs_pkg::SLOT_IDX_W-1:0]   slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ----- rtl/quadratic_probe_hash_set.sv -----
// Quadratic-probing hash set of 31-bit keys.
// req_i: valid/ready request channel, req_type 0 inserts key_value, 1 deletes it.
// rsp_o: valid/ready result channel, one transaction per request with status
//   (0 inserted free, 1 inserted by overwrite, 2 deleted, 3 delete miss) and
//   the slot written or cleared (0 on a miss).
// cfg_we_i/cfg_wdata_i write table_size (reset 11); write it only while idle.
// Each request is handled alone: req_i.ready is high only while the sequencer
// is idle. The home slot comes from a bit-serial remainder over the 31 key
// bits; each probe then runs a key RAM read (S_READ), then a compare and step
// (S_CHECK). The pace is set by the single add/compare/subtract unit that
// serves both the remainder and the probe steps.
// A stalled rsp_o holds its result in the output register; a following request
// waits at its next probe check without touching the table.
// Reset clears all slot flags, the sequencer and the output valid; the key RAM
// needs no clearing since a key is only compared when its in-use flag is set.
module quadratic_probe_hash_set #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qphs_pkg::SIZE_W-1:0] cfg_wdata_i,
  qphs_req_if.sink                    req_i,
  qphs_rsp_if.source                  rsp_o
);

`include "assert_macros.svh"

  // table_size is 5 bits, so no slot at or above 32 is ever reached
  localparam int SLOTS = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
  localparam int AW    = $clog2(SLOTS);
  localparam int SW    = qphs_pkg::SIZE_W;
  localparam int KW    = qphs_pkg::KEY_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  localparam logic [SW:0]   STEP_TWO = (SW+1)'(2);
  localparam logic [SW-1:0] DIV_LAST = SW'(KW - 1);

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] size_q;
  logic [SW-1:0] n_eff;
  logic [SW-1:0] n_q, n_d;
  logic          op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] key_sh_q, key_sh_d;
  logic [SW-1:0] cnt_q, cnt_d;     // divide step, then probe number
  logic [SW-1:0] p_q, p_d;         // remainder during divide, then probe slot
  logic [SW-1:0] pn_q, pn_d;       // next probe slot
  logic [SW-1:0] d_q, d_d;         // 2i+1 mod n
  logic [SLOTS-1:0] in_use_q, in_use_d;
  logic [SLOTS-1:0] ever_q, ever_d;

  logic                              rsp_valid_q, rsp_valid_d;
  logic [qphs_pkg::STATUS_W-1:0]     rsp_status_q, rsp_status_d;
  logic [qphs_pkg::SLOT_IDX_W-1:0]   rsp_slot_q, rsp_slot_d;

  logic [SW-1:0] alu_a;
  logic [SW:0]   alu_b;
  logic [SW-1:0] alu_sum;

  logic [AW-1:0] p_idx;
  logic [KW-1:0] ram_rdata;
  logic          ram_we;
  logic          ram_re;
  logic          out_free;
  logic          last_probe;
  logic          cur_in_use;
  logic          cur_ever;

  // clamp the configured size into 2 .. SLOTS
  always_comb begin
    if (size_q < qphs_pkg::SIZE_MIN) begin
      n_eff = qphs_pkg::SIZE_MIN;
    end else if (int'(size_q) > SLOTS) begin
      n_eff = SW'(SLOTS);
    end else begin
      n_eff = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= qphs_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign p_idx      = p_q[AW-1:0];
  assign cur_in_use = in_use_q[p_idx];
  assign cur_ever   = ever_q[p_idx];
  assign last_probe = (cnt_q == n_q - SW'(1));
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign ram_re     = (state_q == S_READ);

  // Shared unit: remainder steps while dividing, probe stepping afterwards.
  always_comb begin
    alu_a = p_q;
    alu_b = {1'b0, d_q};
    unique case (state_q)
      S_DIV: begin
        // r = 2r + bit mod n
        alu_a = p_q;
        alu_b = {1'b0, p_q} + {{SW{1'b0}}, key_sh_q[KW-1]};
      end
      S_READ: begin
        alu_a = p_q;
        alu_b = {1'b0, d_q};
      end
      S_CHECK: begin
        alu_a = d_q;
        alu_b = STEP_TWO;
      end
      default: begin
        alu_a = p_q;
        alu_b = {1'b0, d_q};
      end
    endcase
  end

  qphs_addmod u_addmod (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .n_i   (n_q),
    .sum_o (alu_sum)
  );

  qphs_ram #(
    .WIDTH (KW),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p_idx),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (p_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    op_d         = op_q;
    key_d        = key_q;
    key_sh_d     = key_sh_q;
    cnt_d        = cnt_q;
    p_d          = p_q;
    pn_d         = pn_q;
    d_d          = d_q;
    in_use_d     = in_use_q;
    ever_d       = ever_q;
    ram_we       = 1'b0;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_slot_d   = rsp_slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          n_d      = n_eff;
          op_d     = req_i.req_type;
          key_d    = req_i.key_value;
          key_sh_d = req_i.key_value;
          cnt_d    = '0;
          p_d      = '0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        p_d      = alu_sum;
        key_sh_d = key_sh_q << 1;
        cnt_d    = cnt_q + SW'(1);
        if (cnt_q == DIV_LAST) begin
          // p now holds the home slot; first step distance is 1
          cnt_d   = '0;
          d_d     = SW'(1);
          state_d = S_READ;
        end
      end
      S_READ: begin
        pn_d    = alu_sum;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // hold the whole step until the output register can take a result
        if (out_free) begin
          if (op_q == qphs_pkg::REQ_INSERT) begin
            if (!cur_in_use || last_probe) begin
              ram_we          = 1'b1;
              in_use_d[p_idx] = 1'b1;
              ever_d[p_idx]   = 1'b1;
              rsp_valid_d     = 1'b1;
              rsp_status_d    = cur_in_use ? qphs_pkg::ST_INSERT_OVERWRITE
                                           : qphs_pkg::ST_INSERT_FREE;
              rsp_slot_d      = p_q[qphs_pkg::SLOT_IDX_W-1:0];
              state_d         = S_IDLE;
            end else begin
              p_d     = pn_q;
              d_d     = alu_sum;
              cnt_d   = cnt_q + SW'(1);
              state_d = S_READ;
            end
          end else begin
            if (!cur_ever) begin
              rsp_valid_d  = 1'b1;
              rsp_status_d = qphs_pkg::ST_DELETE_MISS;
              rsp_slot_d   = '0;
              state_d      = S_IDLE;
            end else if (cur_in_use && (ram_rdata == key_q)) begin
              // keep the ever-used mark as a tombstone
              in_use_d[p_idx] = 1'b0;
              rsp_valid_d     = 1'b1;
              rsp_status_d    = qphs_pkg::ST_DELETED;
              rsp_slot_d      = p_q[qphs_pkg::SLOT_IDX_W-1:0];
              state_d         = S_IDLE;
            end else if (last_probe) begin
              rsp_valid_d  = 1'b1;
              rsp_status_d = qphs_pkg::ST_DELETE_MISS;
              rsp_slot_d   = '0;
              state_d      = S_IDLE;
            end else begin
              p_d     = pn_q;
              d_d     = alu_sum;
              cnt_d   = cnt_q + SW'(1);
              state_d = S_READ;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      ever_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      ever_q      <= ever_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    op_q         <= op_d;
    key_q        <= key_d;
    key_sh_q     <= key_sh_d;
    cnt_q        <= cnt_d;
    p_q          <= p_d;
    pn_q         <= pn_d;
    d_q          <= d_d;
    rsp_status_q <= rsp_status_d;
    rsp_slot_q   <= rsp_slot_d;
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.slot_index = rsp_slot_q;

  `ASSERT_ALWAYS(a_in_use_has_ever, clk_i, rst_ni, (in_use_q & ~ever_q) == '0,
    "slot in use without its ever-used mark")
  `ASSERT_IMPLIES(a_probe_in_range, clk_i, rst_ni,
    (state_q == S_READ) || (state_q == S_CHECK), (p_q < n_q) && (d_q < n_q),
    "probe slot or step outside the table")
  `ASSERT_IMPLIES(a_result_from_check, clk_i, rst_ni, $rose(rsp_valid_q),
    $past(state_q) == S_CHECK, "result raised outside the probe check")
  `ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, req_i.valid && req_i.ready,
    state_q == S_DIV, "accepted request did not start the remainder")

endmodule

// ----- rtl/qphs_ram.sv -----
module qphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/qphs_addmod.sv -----
// Modular add: (a + b) mod n for a < n and a + b < 2n.
module qphs_addmod (
  input  logic [qphs_pkg::SIZE_W-1:0] a_i,
  input  logic [qphs_pkg::SIZE_W:0]   b_i,
  input  logic [qphs_pkg::SIZE_W-1:0] n_i,
  output logic [qphs_pkg::SIZE_W-1:0] sum_o
);

  logic [qphs_pkg::SIZE_W+1:0] sum;
  logic [qphs_pkg::SIZE_W+1:0] n_ext;

  always_comb begin
    sum   = {2'b00, a_i} + {1'b0, b_i};
    n_ext = {2'b00, n_i};
    if (sum >= n_ext) begin
      sum_o = qphs_pkg::SIZE_W'(sum - n_ext);
    end else begin
      sum_o = qphs_pkg::SIZE_W'(sum);
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int KEY_W        = qphs_pkg::KEY_W;
  localparam int STATUS_W     = qphs_pkg::STATUS_W;
  localparam int SLOT_IDX_W   = qphs_pkg::SLOT_IDX_W;
  localparam int SIZE_W       = qphs_pkg::SIZE_W;

  localparam int TABLE_DEPTH  = 16;
  localparam int PHASE_ITEMS  = 50;
  // A request touches at most TABLE_DEPTH slots; the drain wait leaves margin past the slowest one.
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot;
  } hash_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [SIZE_W-1:0]     cfg_wdata_i;

  qphs_req_if req_if ();
  qphs_rsp_if rsp_if ();

  quadratic_probe_hash_set #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the table, advanced at every accepted request.
  logic [KEY_W-1:0]  shadow_key       [TABLE_DEPTH];
  bit                shadow_in_use    [TABLE_DEPTH];
  bit                shadow_ever_used [TABLE_DEPTH];
  logic [SIZE_W-1:0] shadow_size;

  hash_req_t        pending_req_q[$];
  hash_rsp_t        expected_rsp_q[$];
  logic [KEY_W-1:0] live_keys[$];

  hash_req_t offered_req;
  bit        quiet;
  int        gap_left;
  int        stall_left;
  int        hold_left;
  int        results_seen;
  int        errors;
  int        cycle_cnt;

  // Apply one request to the shadow table and return the result it must produce.
  function automatic hash_rsp_t hash_set_apply(hash_req_t req);
    int unsigned n;
    int unsigned home;
    int unsigned probe;
    hash_rsp_t   rsp;

    n = shadow_size;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    home = req.key % n;
    rsp.slot = '0;
    if (req.req_type == qphs_pkg::REQ_INSERT) begin
      probe = home;
      rsp.status = qphs_pkg::ST_INSERT_FREE;
      if (shadow_in_use[home]) begin
        // Walk the quadratic sequence; if nothing free turns up, the last
        // probed slot is overwritten.
        rsp.status = qphs_pkg::ST_INSERT_OVERWRITE;
        for (int unsigned i = 1; i < n; i++) begin
          probe = (home + i * i) % n;
          if (!shadow_in_use[probe]) begin
            rsp.status = qphs_pkg::ST_INSERT_FREE;
            break;
          end
        end
      end
      shadow_key[probe]       = req.key;
      shadow_in_use[probe]    = 1'b1;
      shadow_ever_used[probe] = 1'b1;
      rsp.slot = probe[SLOT_IDX_W-1:0];
    end else begin
      rsp.status = qphs_pkg::ST_DELETE_MISS;
      for (int unsigned i = 0; i < n; i++) begin
        probe = (home + i * i) % n;
        // A never-used slot ends the chain; tombstones are skipped over.
        if (!shadow_ever_used[probe]) break;
        if (shadow_in_use[probe] && shadow_key[probe] == req.key) begin
          shadow_in_use[probe] = 1'b0;
          shadow_key[probe]    = '0;
          rsp.status = qphs_pkg::ST_DELETED;
          rsp.slot   = probe[SLOT_IDX_W-1:0];
          break;
        end
      end
    end
    return rsp;
  endfunction

  task automatic push_req(logic req_type, logic [KEY_W-1:0] key);
    pending_req_q.push_back('{req_type: req_type, key: key});
  endtask

  // Mostly well-formed traffic: inserts, deletes of keys that were inserted,
  // and some deletes of arbitrary keys that should usually miss.
  task automatic queue_random(int count);
    int               pick;
    int               idx;
    logic [KEY_W-1:0] key;

    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 || (pick < 8 && live_keys.size() == 0)) begin
        if ($urandom_range(0, 1) == 0) key = KEY_W'($urandom_range(0, 63));
        else key = KEY_W'($urandom());
        live_keys.push_back(key);
        push_req(qphs_pkg::REQ_INSERT, key);
      end else if (pick < 8) begin
        idx = $urandom_range(0, live_keys.size() - 1);
        key = live_keys[idx];
        live_keys.delete(idx);
        push_req(qphs_pkg::REQ_DELETE, key);
      end else begin
        key = KEY_W'($urandom());
        push_req(qphs_pkg::REQ_DELETE, key);
      end
    end
  endtask

  // Hold until every queued request is accepted and every result has come back,
  // then wait while the block settles in its idle state.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Drive every input to a known value from time zero, pulse reset once, then
  // run the phases: directed checks at the reset size, random traffic across
  // a spread of sizes, and a final phase with no idling on either side.
  initial begin
    logic [SIZE_W-1:0] sizes[$];

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.req_type  = qphs_pkg::REQ_INSERT;
    req_if.key_value = '0;
    rsp_if.ready     = 1'b0;
    quiet            = 1'b0;
    errors           = 0;
    shadow_size      = qphs_pkg::SIZE_RESET;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      shadow_key[s]       = '0;
      shadow_in_use[s]    = 1'b0;
      shadow_ever_used[s] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset size of 11.
    push_req(qphs_pkg::REQ_INSERT, '0);
    push_req(qphs_pkg::REQ_INSERT, '1);
    push_req(qphs_pkg::REQ_INSERT, 31'd11);   // collides with key 0, probes onward
    push_req(qphs_pkg::REQ_INSERT, '0);       // duplicate key is stored a second time
    push_req(qphs_pkg::REQ_DELETE, '0);
    push_req(qphs_pkg::REQ_DELETE, '0);       // removes the duplicate copy
    push_req(qphs_pkg::REQ_DELETE, '0);       // walks tombstones, stops at a never-used slot
    push_req(qphs_pkg::REQ_DELETE, 31'd5);    // miss on an empty chain
    push_req(qphs_pkg::REQ_INSERT, 31'd22);   // reuses the tombstone at the home slot
    for (int k = 3; k <= 9; k++) push_req(qphs_pkg::REQ_INSERT, KEY_W'(11 * k));
    // The home-0 chain reaches only six slots of eleven: later inserts overwrite.
    push_req(qphs_pkg::REQ_INSERT, 31'd110);
    push_req(qphs_pkg::REQ_DELETE, '1);
    push_req(qphs_pkg::REQ_INSERT, '1);
    push_req(qphs_pkg::REQ_DELETE, 31'd110);
    push_req(qphs_pkg::REQ_DELETE, 31'd55);
    wait_idle();

    // Sizes below the minimum and above the depth clamp; the rest are in range.
    sizes = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd31, 5'd17, 5'd3, 5'd7,
              SIZE_W'($urandom_range(2, 15))};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    // Last phase: back to the reset size, both sides at full rate.
    quiet = 1'b1;
    write_size(qphs_pkg::SIZE_RESET);
    queue_random(PHASE_ITEMS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_rsp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Request driver: keep an offered transaction stable until it is taken,
  // record the expected result at acceptance, insert random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(hash_set_apply(offered_req));
      end
      if (req_if.valid && !req_if.ready) begin
        // hold: the block has not taken the current request yet
      end else if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left--;
      end else if (!quiet && pending_req_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        // start a random idle burst
        req_if.valid <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else if (pending_req_q.size() != 0) begin
        offered_req = pending_req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.req_type  <= offered_req.req_type;
        req_if.key_value <= offered_req.key;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each result with the oldest expectation, and
  // stall ready in random bursts plus one long hold-off that backs the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    hash_rsp_t exp_rsp;

    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      results_seen = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result status %0d slot %0d", $time,
                   rsp_if.status, rsp_if.slot_index);
          errors++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.slot_index !== exp_rsp.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $time,
                     exp_rsp.slot, rsp_if.slot_index);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if it goes far past the slowest correct pace.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("simulation failed");
    $finish;
  end

endmodule
